>>> rtl/core/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants for the bounded ordered list engine
// Sizes of the list storage, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_KEY  = 3'd2,
    MODE_DEL_HEAD = 3'd3,
    MODE_DEL_TAIL = 3'd4,
    MODE_DEL_KEY  = 3'd5,
    MODE_SEARCH   = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

>>> rtl/core/bole_in_if.sv
// ----------------------------------------------------------------------------
// bole_in_if: operation channel of the ordered list engine
// Valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface bole_in_if;
  logic                                valid;
  logic                                ready;
  logic        [bole_pkg::MODE_W-1:0]  mode;
  logic signed [bole_pkg::DATA_W-1:0]  value;
  logic signed [bole_pkg::DATA_W-1:0]  key;

  modport source (output valid, output mode, output value, output key, input ready);
  modport sink   (input valid, input mode, input value, input key, output ready);
endinterface

>>> rtl/core/bole_out_if.sv
// ----------------------------------------------------------------------------
// bole_out_if: result channel of the ordered list engine
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface bole_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bole_pkg::STATUS_W-1:0]  status;
  logic        [bole_pkg::CNT_W-1:0]     position;
  logic signed [bole_pkg::DATA_W-1:0]    removed_value;
  logic        [bole_pkg::CNT_W-1:0]     length;

  modport source (output valid, output status, output position, output removed_value,
                  output length, input ready);
  modport sink   (input valid, input status, input position, input removed_value,
                  input length, output ready);
endinterface

>>> rtl/core/bole_ram.sv
// ----------------------------------------------------------------------------
// bole_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/bounded_ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core: ordered list of signed words
// Keeps up to DEPTH words in a RAM, head at address 0, and runs insert,
// delete and search operations through a small sequencer around the RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  in_i    | in  | valid/ready   | mode, value, key
//  out_o   | out | valid/ready   | status, position, removed_value, length
//
//  Operations that touch no entry answer straight from the idle state. A search
//  reads one entry per cycle, an insert moves one entry per cycle from the tail
//  down to the slot, a delete one entry per cycle from the slot up to the tail.
//  The search stops at the match, where a delete's shift starts and an insert's
//  shift ends. The single RAM read port sets this pace. The RAM needs no clearing
//  after reset; only the state, the element count and the output valid are
//  cleared. A pending result stalls the next operation only until it is taken.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bole_in_if.sink     in_i,
  bole_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SRCH = 4'b0010,
    ST_INS  = 4'b0100,
    ST_DEL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bole_pkg::CNT_W-1:0]  count_q, count_d;
  logic [bole_pkg::IDX_W-1:0]  ptr_q, ptr_d;
  logic [bole_pkg::IDX_W-1:0]  tgt_q, tgt_d;
  logic [bole_pkg::CNT_W-1:0]  pos_q, pos_d;
  logic [bole_pkg::DATA_W-1:0] rem_q, rem_d;
  bole_pkg::mode_e             mode_q;
  logic [bole_pkg::DATA_W-1:0] value_q;
  logic [bole_pkg::DATA_W-1:0] key_q;

  logic                         out_valid_q, out_valid_d;
  logic [bole_pkg::STATUS_W-1:0] out_status_q;
  logic [bole_pkg::CNT_W-1:0]    out_pos_q;
  logic [bole_pkg::DATA_W-1:0]   out_rem_q;
  logic [bole_pkg::CNT_W-1:0]    out_len_q;

  logic                         ram_we;
  logic [bole_pkg::IDX_W-1:0]   ram_waddr;
  logic [bole_pkg::DATA_W-1:0]  ram_wdata;
  logic [bole_pkg::IDX_W-1:0]   ram_raddr;
  logic [bole_pkg::DATA_W-1:0]  ram_rdata;

  logic                          done;
  bole_pkg::status_e             res_status;
  logic [bole_pkg::CNT_W-1:0]    res_pos;
  logic [bole_pkg::DATA_W-1:0]   res_rem;

  logic                         in_fire, out_fire;
  bole_pkg::mode_e              in_mode;
  logic                         full, empty;
  logic [bole_pkg::IDX_W-1:0]   count_idx;
  logic [bole_pkg::IDX_W-1:0]   ptr_nxt;
  logic [bole_pkg::CNT_W-1:0]   ptr_pos;
  logic                         last, hit;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  assign in_mode   = bole_pkg::mode_e'(in_i.mode);
  assign full      = (count_q == bole_pkg::CNT_W'(bole_pkg::DEPTH));
  assign empty     = (count_q == '0);
  assign count_idx = count_q[bole_pkg::IDX_W-1:0];
  assign ptr_nxt   = ptr_q + 1'b1;
  assign ptr_pos   = bole_pkg::CNT_W'(ptr_q) + bole_pkg::CNT_W'(1);
  assign last      = (ptr_pos == count_q);
  assign hit       = (ram_rdata == key_q);

  bole_ram #(
    .WIDTH (bole_pkg::DATA_W),
    .DEPTH (bole_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    tgt_d      = tgt_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = '0;
    done       = 1'b0;
    res_status = bole_pkg::ST_OK;
    res_pos    = '0;
    res_rem    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pos_d = '0;
          case (in_mode)
            bole_pkg::MODE_INS_HEAD, bole_pkg::MODE_INS_TAIL,
            bole_pkg::MODE_INS_KEY: begin
              if (full) begin
                done       = 1'b1;
                res_status = bole_pkg::ST_FULL;
              end else if (empty || in_mode == bole_pkg::MODE_INS_HEAD) begin
                // Entries from the tail down to the head move up one slot.
                tgt_d     = '0;
                ptr_d     = count_idx;
                ram_raddr = count_idx - 1'b1;
                state_d   = ST_INS;
              end else if (in_mode == bole_pkg::MODE_INS_TAIL) begin
                tgt_d   = count_idx;
                ptr_d   = count_idx;
                state_d = ST_INS;
              end else begin
                ptr_d   = '0;
                state_d = ST_SRCH;
              end
            end
            bole_pkg::MODE_DEL_HEAD, bole_pkg::MODE_DEL_TAIL: begin
              if (empty) begin
                done       = 1'b1;
                res_status = bole_pkg::ST_EMPTY;
              end else begin
                tgt_d     = (in_mode == bole_pkg::MODE_DEL_TAIL) ? count_idx - 1'b1 : '0;
                ptr_d     = tgt_d;
                ram_raddr = tgt_d;
                state_d   = ST_DEL;
              end
            end
            bole_pkg::MODE_DEL_KEY: begin
              if (empty) begin
                done       = 1'b1;
                res_status = bole_pkg::ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = ST_SRCH;
              end
            end
            bole_pkg::MODE_SEARCH: begin
              if (empty) begin
                done       = 1'b1;
                res_status = bole_pkg::ST_NOT_FOUND;
              end else begin
                ptr_d   = '0;
                state_d = ST_SRCH;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_SRCH: begin
        // The read data holds the entry at ptr_q.
        if (hit) begin
          pos_d = ptr_pos;
          case (mode_q)
            bole_pkg::MODE_SEARCH: begin
              done    = 1'b1;
              res_pos = ptr_pos;
            end
            bole_pkg::MODE_INS_KEY: begin
              tgt_d     = ptr_nxt;
              ptr_d     = count_idx;
              ram_raddr = count_idx - 1'b1;
              state_d   = ST_INS;
            end
            default: begin
              tgt_d     = ptr_q;
              ram_raddr = ptr_q;
              state_d   = ST_DEL;
            end
          endcase
        end else if (last) begin
          if (mode_q == bole_pkg::MODE_DEL_KEY && count_q == bole_pkg::CNT_W'(1)) begin
            // A single element goes whether or not the key matched.
            tgt_d     = '0;
            ptr_d     = '0;
            ram_raddr = '0;
            state_d   = ST_DEL;
          end else begin
            done       = 1'b1;
            res_status = bole_pkg::ST_NOT_FOUND;
          end
        end else begin
          ptr_d     = ptr_nxt;
          ram_raddr = ptr_nxt;
        end
      end

      ST_INS: begin
        ram_we = 1'b1;
        if (ptr_q == tgt_q) begin
          ram_waddr = tgt_q;
          ram_wdata = value_q;
          done      = 1'b1;
          res_pos   = pos_q;
          count_d   = count_q + 1'b1;
        end else begin
          ram_waddr = ptr_q;
          ram_wdata = ram_rdata;
          ram_raddr = ptr_q - 2'd2;
          ptr_d     = ptr_q - 1'b1;
        end
      end

      ST_DEL: begin
        if (ptr_q == tgt_q) begin
          rem_d = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (last) begin
          done    = 1'b1;
          res_pos = pos_q;
          res_rem = (ptr_q == tgt_q) ? ram_rdata : rem_q;
          count_d = count_q - 1'b1;
        end else begin
          ptr_d     = ptr_nxt;
          ram_raddr = ptr_nxt;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (done) begin
      state_d = ST_IDLE;
    end

    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tgt_q <= tgt_d;
    pos_q <= pos_d;
    rem_q <= rem_d;
    if (in_fire) begin
      mode_q  <= in_mode;
      value_q <= in_i.value;
      key_q   <= in_i.key;
    end
    if (done) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos;
      out_rem_q    <= res_rem;
      out_len_q    <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.position      = out_pos_q;
  assign out_o.removed_value = out_rem_q;
  assign out_o.length        = out_len_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bole_pkg::CNT_W'(bole_pkg::DEPTH))
    else $error("element count beyond list depth");

  a_we_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_INS || state_q == ST_DEL))
    else $error("list storage written outside a shift");

  a_ins_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS && ptr_q == tgt_q) |=> count_q == $past(count_q) + 1'b1)
    else $error("finished insert did not grow the list by one");

  a_len_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && state_q != ST_IDLE) |=> out_o.length == count_q)
    else $error("reported length differs from element count");

endmodule
